// File: rtl/core/irc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval room counter package
// Shared widths, constants and types of the interval room counter.
// ----------------------------------------------------------------------------
package irc_pkg;

  localparam int unsigned TIME_W        = 32;
  localparam int unsigned ROOMS_W       = 9;
  localparam int unsigned HEAP_DEPTH_DEF = 256;

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [TIME_W-1:0]  KEY_FLIP  = {1'b1, {(TIME_W-1){1'b0}}};
  localparam logic [ROOMS_W-1:0] ROOMS_MAX = '1;

  typedef struct packed {
    logic              first_of_set;
    logic [TIME_W-1:0] start_key;
    logic [TIME_W-1:0] end_key;
  } irc_req_t;

  typedef struct packed {
    logic [ROOMS_W-1:0] rooms_in_use;
    logic               overflow;
  } irc_res_t;

endpackage

// File: rtl/core/irc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval room counter channels
// Valid/ready channels for interval items and room count items.
// ----------------------------------------------------------------------------
interface irc_in_if
  import irc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     first_of_set;
  logic signed [TIME_W-1:0] start_time;
  logic signed [TIME_W-1:0] end_time;

  modport source (output valid, first_of_set, start_time, end_time, input ready);
  modport sink   (input valid, first_of_set, start_time, end_time, output ready);
endinterface

interface irc_out_if
  import irc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ROOMS_W-1:0] rooms_in_use;
  logic               overflow;

  modport source (output valid, rooms_in_use, overflow, input ready);
  modport sink   (input valid, rooms_in_use, overflow, output ready);
endinterface

// File: rtl/core/irc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module irc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/irc_heap_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval room counter heap sequencer
// Keeps the min-heap of end times in RAM and walks it one level at a time,
// using a single key comparator for both sift-up and sift-down.
// ----------------------------------------------------------------------------
module irc_heap_ctrl
  import irc_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  irc_req_t req_i,
  input  logic     hold_i,
  output logic     idle_o,
  output logic     done_o,
  output irc_res_t res_o
);

  localparam int unsigned AW    = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW    = AW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN_RD_L,
    ST_DN_RD_R,
    ST_DN_CMP,
    ST_PUT,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [TIME_W-1:0] key_q, key_d;
  logic [TIME_W-1:0] root_q;
  logic [TIME_W-1:0] lc_data_q, lc_data_d;
  logic              lc_best_q, lc_best_d;
  logic              rc_ok_q, rc_ok_d;
  logic              ovf_q, ovf_d;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [TIME_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [TIME_W-1:0] rdata;

  logic [AW-1:0]     parent;
  logic [IW-1:0]     lc_ix;
  logic [IW-1:0]     rc_ix;
  logic [IW-1:0]     cnt_ix;

  // The one comparator of the block; its operands are chosen per state.
  logic [TIME_W-1:0] cmp_a;
  logic [TIME_W-1:0] cmp_b;
  logic              a_lt_b;

  irc_ram #(
    .WIDTH (TIME_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign parent = AW'((pos_q - AW'(1)) >> 1);
  assign lc_ix  = {1'b0, pos_q, 1'b1};
  assign rc_ix  = lc_ix + IW'(1);
  assign cnt_ix = IW'(count_q);
  assign a_lt_b = cmp_a < cmp_b;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    key_d     = key_q;
    lc_data_d = lc_data_q;
    lc_best_d = lc_best_q;
    rc_ok_d   = rc_ok_q;
    ovf_d     = ovf_q;
    we        = 1'b0;
    waddr     = pos_q;
    wdata     = key_q;
    raddr     = parent;
    cmp_a     = req_i.start_key;
    cmp_b     = root_q;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          key_d = req_i.end_key;
          pos_d = '0;
          ovf_d = 1'b0;
          if (req_i.first_of_set || count_q == '0) begin
            we      = 1'b1;
            waddr   = '0;
            wdata   = req_i.end_key;
            count_d = CNT_W'(1);
            state_d = ST_FINISH;
          end else if (!a_lt_b) begin
            // Pop and push together: the new end replaces the root.
            if (count_q == CNT_W'(1)) begin
              we      = 1'b1;
              waddr   = '0;
              wdata   = req_i.end_key;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_DN_RD_L;
            end
          end else if (count_q == CNT_W'(HEAP_DEPTH)) begin
            ovf_d   = 1'b1;
            state_d = ST_FINISH;
          end else begin
            pos_d   = AW'(count_q);
            count_d = count_q + CNT_W'(1);
            state_d = ST_UP_RD;
          end
        end
      end
      ST_UP_RD: begin
        raddr   = parent;
        state_d = ST_UP_WR;
      end
      ST_UP_WR: begin
        cmp_a = key_q;
        cmp_b = rdata;
        we    = 1'b1;
        if (a_lt_b) begin
          wdata = rdata;
          pos_d = parent;
          state_d = (parent == '0) ? ST_PUT : ST_UP_RD;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DN_RD_L: begin
        if (lc_ix >= cnt_ix) begin
          state_d = ST_PUT;
        end else begin
          raddr   = AW'(lc_ix);
          state_d = ST_DN_RD_R;
        end
      end
      ST_DN_RD_R: begin
        // Keep the smaller of the left child and the sinking key.
        cmp_a     = rdata;
        cmp_b     = key_q;
        lc_data_d = a_lt_b ? rdata : key_q;
        lc_best_d = a_lt_b;
        rc_ok_d   = rc_ix < cnt_ix;
        raddr     = AW'(rc_ix);
        state_d   = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmp_a = rdata;
        cmp_b = lc_data_q;
        if (rc_ok_q && a_lt_b) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_d   = AW'(rc_ix);
          state_d = ST_DN_RD_L;
        end else if (lc_best_q) begin
          we      = 1'b1;
          wdata   = lc_data_q;
          pos_d   = AW'(lc_ix);
          state_d = ST_DN_RD_L;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        we      = 1'b1;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!hold_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      rc_ok_q   <= 1'b0;
      pos_q     <= '0;
      key_q     <= '0;
      lc_data_q <= '0;
      lc_best_q <= 1'b0;
      root_q    <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      rc_ok_q   <= rc_ok_d;
      pos_q     <= pos_d;
      key_q     <= key_d;
      lc_data_q <= lc_data_d;
      lc_best_q <= lc_best_d;
      if (we && waddr == '0) begin
        root_q <= wdata;
      end
    end
  end

  assign idle_o          = state_q == ST_IDLE;
  assign done_o          = (state_q == ST_FINISH) && !hold_i;
  assign res_o.overflow  = ovf_q;
  assign res_o.rooms_in_use = (32'(count_q) > 32'(ROOMS_MAX)) ? ROOMS_MAX
                                                              : ROOMS_W'(count_q);

endmodule

// File: rtl/core/interval_room_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval room counter
// Minimum-rooms interval partitioning over a binary min-heap of end times.
// ----------------------------------------------------------------------------
// Each input item is one interval, sorted by start within a set; an item with
// first_of_set high empties the heap and opens a new set. Every item yields
// one item carrying the rooms in use so far and an overflow flag, raised when
// the heap is full, nothing could be released and the end time was dropped.
// The block works on one interval at a time and is not ready until its result
// has been handed to the output register. The time taken is set by the heap
// walk over the RAM with one write port and one read port: an insertion
// reads and compares one parent per level while the new end climbs, and a
// reuse reads the left and then the right child per level while the end
// sinks. No walk is needed when a set opens, when the heap is empty, when it
// overflows or when it holds only the room being reused. While the output
// register is still full, the finished item waits and the input stays not
// ready. The heap RAM needs no clearing after reset.
module interval_room_counter
  import irc_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = HEAP_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  irc_in_if.sink    in_i,
  irc_out_if.source out_o
);

  localparam logic [ROOMS_W-1:0] ROOMS_FULL =
    (HEAP_DEPTH > 32'(ROOMS_MAX)) ? ROOMS_MAX : ROOMS_W'(HEAP_DEPTH);

  irc_req_t req;
  irc_res_t res;
  logic     ctrl_idle;
  logic     ctrl_done;
  logic     hold;

  logic               out_valid_q;
  logic [ROOMS_W-1:0] out_rooms_q;
  logic               out_ovf_q;

  assign req.first_of_set = in_i.first_of_set;
  assign req.start_key    = in_i.start_time ^ KEY_FLIP;
  assign req.end_key      = in_i.end_time ^ KEY_FLIP;

  assign in_i.ready = ctrl_idle;
  assign hold       = out_valid_q && !out_o.ready;

  irc_heap_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_heap_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_i       (req),
    .hold_i      (hold),
    .idle_o      (ctrl_idle),
    .done_o      (ctrl_done),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_rooms_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (ctrl_done) begin
        out_valid_q <= 1'b1;
        out_rooms_q <= res.rooms_in_use;
        out_ovf_q   <= res.overflow;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rooms_in_use = out_rooms_q;
  assign out_o.overflow     = out_ovf_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input still ready after an item was accepted");

  a_done_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_done |=> out_o.valid)
    else $error("finished item did not reach the output register");

  a_rooms_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.rooms_in_use != '0)
    else $error("room count of zero after an item");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflow |-> out_o.rooms_in_use == ROOMS_FULL)
    else $error("overflow reported while the heap was not full");

endmodule

// File: sim/interval_room_counter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval room counter regression
// Drives interval sets, mostly sorted by start, through the block, keeps a
// model of the open end times in use and checks every room count item,
// overflow included, in order.
module interval_room_counter_test;
  import irc_pkg::*;

  localparam int unsigned ROOM_LIMIT = HEAP_DEPTH_DEF;
  localparam longint     TIME_MIN   = -64'sd2147483648;
  localparam longint     TIME_MAX   = 64'sd2147483647;

  typedef struct {
    bit                       first_of_set;
    logic signed [TIME_W-1:0] start_time;
    logic signed [TIME_W-1:0] end_time;
  } interval_t;

  logic clk_i;
  logic rst_ni;

  irc_in_if  in_if ();
  irc_out_if out_if ();

  interval_room_counter #(
    .HEAP_DEPTH(ROOM_LIMIT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  interval_t                pending_intervals[$];
  irc_res_t                 rooms_expected[$];
  logic signed [TIME_W-1:0] open_ends[$];
  interval_t                on_wire;
  int unsigned              send_idle_pct;
  int unsigned              recv_idle_pct;
  int unsigned              fault_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic irc_res_t book_interval(interval_t iv);
    irc_res_t res;
    int       earliest;
    earliest = 0;
    if (iv.first_of_set) begin
      open_ends.delete();
    end else if (open_ends.size() != 0) begin
      for (int k = 1; k < open_ends.size(); k++) begin
        if (open_ends[k] < open_ends[earliest]) earliest = k;
      end
      if (iv.start_time >= open_ends[earliest]) open_ends.delete(earliest);
    end
    res.overflow = (open_ends.size() >= ROOM_LIMIT);
    if (!res.overflow) open_ends.push_back(iv.end_time);
    res.rooms_in_use = (open_ends.size() > ROOMS_MAX) ? ROOMS_MAX
                                                      : ROOMS_W'(open_ends.size());
    return res;
  endfunction

  function automatic logic signed [TIME_W-1:0] clamp_time(longint t);
    if (t > TIME_MAX) return TIME_W'(TIME_MAX);
    if (t < TIME_MIN) return TIME_W'(TIME_MIN);
    return TIME_W'(t);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : interval_driver
    bit offering;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      offering = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        rooms_expected.push_back(book_interval(on_wire));
        offering = 1'b0;
      end
      if (!offering && pending_intervals.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        on_wire  = pending_intervals.pop_front();
        offering = 1'b1;
      end
      in_if.valid        <= offering;
      in_if.first_of_set <= on_wire.first_of_set;
      in_if.start_time   <= on_wire.start_time;
      in_if.end_time     <= on_wire.end_time;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : room_monitor
    irc_res_t due;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (rooms_expected.size() == 0) begin
          $error("unexpected item: rooms_in_use %0d overflow %0b",
                 out_if.rooms_in_use, out_if.overflow);
          fault_count++;
        end else begin
          due = rooms_expected.pop_front();
          if (out_if.rooms_in_use !== due.rooms_in_use) begin
            $error("rooms_in_use: expected %0d, actual %0d",
                   due.rooms_in_use, out_if.rooms_in_use);
            fault_count++;
          end
          if (out_if.overflow !== due.overflow) begin
            $error("overflow: expected %0b, actual %0b", due.overflow, out_if.overflow);
            fault_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_interval(bit first, longint start_t, longint end_t);
    interval_t iv;
    iv.first_of_set = first;
    iv.start_time   = clamp_time(start_t);
    iv.end_time     = clamp_time(end_t);
    pending_intervals.push_back(iv);
  endtask

  // Starts rise in most sets; the spread of starts and durations varies so
  // that some sets reuse rooms all the time and others stack up deep heaps.
  task automatic queue_random_set(int n);
    longint      t;
    longint      span;
    int unsigned flavour;
    bit          opens;
    t       = longint'(signed'($urandom()));
    flavour = $urandom_range(19);
    opens   = ($urandom_range(9) != 0);
    case ($urandom_range(3))
      0: span = 1;
      1: span = 64;
      2: span = 64'd1 << 20;
      default: span = 64'd1 << 28;
    endcase
    for (int k = 0; k < n; k++) begin
      if (flavour == 0) begin
        t = longint'(signed'($urandom()));
      end else if (k > 0) begin
        t = t + longint'($urandom_range(0, int'(span)));
        if (t > TIME_MAX) t = TIME_MAX;
      end
      case ($urandom_range(15))
        0: queue_interval(opens && k == 0, t, longint'(signed'($urandom())));
        1: queue_interval(opens && k == 0, t, t - longint'($urandom_range(0, int'(span))));
        default: queue_interval(opens && k == 0, t,
                                t + longint'($urandom_range(0, int'(4 * span))));
      endcase
    end
  endtask

  task automatic wait_until_idle();
    while (pending_intervals.size() != 0 || in_if.valid || rooms_expected.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int quota);
    int queued;
    queued        = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (queued < quota) begin
      int n;
      n = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      queue_random_set(n);
      queued += n;
    end
    wait_until_idle();
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.first_of_set = 1'b0;
    in_if.start_time   = '0;
    in_if.end_time     = '0;
    out_if.ready       = 1'b0;
    on_wire            = '{1'b0, '0, '0};
    fault_count        = 0;
    send_idle_pct      = 12;
    recv_idle_pct      = 74;

    queue_interval(1'b0, 0, 5);
    queue_interval(1'b1, TIME_MIN, TIME_MIN);
    queue_interval(1'b0, TIME_MIN, TIME_MAX);
    queue_interval(1'b0, TIME_MAX, TIME_MAX);
    queue_interval(1'b0, TIME_MAX, -1);
    queue_interval(1'b1, -10, -5);
    queue_interval(1'b0, -6, 0);
    queue_interval(1'b0, -5, 3);
    queue_interval(1'b0, -5, -5);
    queue_interval(1'b0, 3, 32'sh5555_5555);
    queue_interval(1'b0, 32'sh5555_5555, 32'shAAAA_AAAA);
    queue_interval(1'b0, 32'sh5555_5555, -2);
    queue_interval(1'b1, 100, 50);
    queue_interval(1'b0, 100, 100);
    queue_interval(1'b0, 100, TIME_MIN);
    queue_interval(1'b0, TIME_MIN, TIME_MIN);

    // Fill the heap with ends that no start reaches, so that it runs full.
    queue_interval(1'b1, 0, 100000);
    for (int k = 1; k < 270; k++) queue_interval(1'b0, k, 100000 + k);
    queue_interval(1'b0, 200000, 300000);
    queue_interval(1'b0, 0, 5);
    queue_interval(1'b0, TIME_MAX, TIME_MAX);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_phase(12, 74, 170);
    run_phase(74, 12, 170);
    run_phase(0, 0, 170);

    repeat (60) @(negedge clk_i);
    if (fault_count == 0 && rooms_expected.size() == 0) begin
      $display("interval_room_counter regression: pass");
    end else begin
      $display("interval_room_counter regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("interval_room_counter regression: fail");
    $finish;
  end

endmodule
